// ===== design/dmd_pkg.sv =====
// Shared constants, types and helpers for the delimited message deframer.
package dmd_pkg;

    localparam int MAX_DELIM_BYTES = 8;
    localparam int BYTE_W          = 8;
    localparam int DELIM_W         = MAX_DELIM_BYTES * BYTE_W;
    localparam int LEN_W           = 4;
    localparam int IDX_W           = $clog2(MAX_DELIM_BYTES);
    localparam int CELLS           = MAX_DELIM_BYTES - 1;
    localparam int MAXSZ_W         = 16;
    localparam int COUNT_W         = MAXSZ_W + 1;
    localparam int CFG_IDX_W       = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE     = 2'd2;

    // Status codes carried by an end-of-message transaction.
    typedef enum logic [1:0] {
        STATUS_ACCEPTED = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } status_t;

    // Per-cell control from the top level.
    typedef struct packed {
        logic              shift;
        logic              in_use;
        logic [BYTE_W-1:0] expected;
    } cell_ctl_t;

    // Picks delimiter byte idx; byte 0 sits in the lowest octet.
    function automatic logic [BYTE_W-1:0] delim_byte(input logic [DELIM_W-1:0] bytes,
                                                      input logic [IDX_W-1:0] idx);
        return bytes[{idx, 3'b000} +: BYTE_W];
    endfunction

endpackage

// ===== design/delimited_message_deframer.sv =====
// Top level of the delimited message deframer: cell chain, counters and output register.
// A result is registered and appears on the m_ side in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the single output register lets a new byte enter
// while the previous result is taken, so only a stalled m_ready slows the input.
// Reset (aresetn low, synchronous) empties the window, clears the message count and
// the output valid flag, and restores the line feed delimiter with a maximum of 1024.
module delimited_message_deframer (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dmd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dmd_pkg::DELIM_W-1:0]       cfg_data,
    // Byte input channel.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [dmd_pkg::BYTE_W-1:0]        s_data_byte,
    // Result channel.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_is_end,
    output logic [dmd_pkg::BYTE_W-1:0]        m_out_byte,
    output logic [dmd_pkg::COUNT_W-1:0]       m_message_length,
    output logic [1:0]                        m_status
);

    // Configuration registers.
    logic [dmd_pkg::DELIM_W-1:0] delim_reg;
    logic [dmd_pkg::LEN_W-1:0]   len_reg;
    logic [dmd_pkg::MAXSZ_W-1:0] max_reg;

    // Control state.
    logic [dmd_pkg::IDX_W-1:0]   held_count_reg, held_count_next;
    logic [dmd_pkg::COUNT_W-1:0] msg_count_reg, msg_count_next;

    // Output register.
    logic                        m_valid_reg, m_valid_next;
    logic                        is_end_reg, is_end_next;
    logic [dmd_pkg::BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic [dmd_pkg::COUNT_W-1:0] length_reg, length_next;
    logic [1:0]                  status_reg, status_next;

    logic                        in_acc;
    logic                        cfg_acc;
    logic [dmd_pkg::IDX_W-1:0]   lm1;        // effective delimiter length minus one
    logic [dmd_pkg::IDX_W-1:0]   held_eff;
    logic                        full;
    logic                        match;
    logic [dmd_pkg::BYTE_W-1:0]  oldest_byte;
    logic [dmd_pkg::COUNT_W-1:0] max_ext;

    logic [dmd_pkg::BYTE_W-1:0]  cell_byte  [dmd_pkg::CELLS];
    logic                        cell_match [dmd_pkg::CELLS];
    dmd_pkg::cell_ctl_t          cell_ctl   [dmd_pkg::CELLS];
    logic                        head_match;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid & cfg_ready;

    // A new byte is taken whenever the output register is empty or is being drained.
    assign s_ready = ~m_valid_reg | m_ready;
    assign in_acc  = s_valid & s_ready;

    // A length of zero behaves as one, anything above the maximum as the maximum.
    always_comb begin
        if (len_reg == '0) begin
            lm1 = '0;
        end else if (len_reg > dmd_pkg::LEN_W'(dmd_pkg::MAX_DELIM_BYTES)) begin
            lm1 = dmd_pkg::IDX_W'(dmd_pkg::MAX_DELIM_BYTES - 1);
        end else begin
            lm1 = dmd_pkg::IDX_W'(len_reg - dmd_pkg::LEN_W'(1));
        end
    end

    assign held_eff = (held_count_reg > lm1) ? lm1 : held_count_reg;
    // The window plus the new byte fills the delimiter exactly when the held
    // count has reached length minus one.
    assign full     = (held_eff == lm1);
    assign max_ext  = {1'b0, max_reg};

    // The window is a shift line: cell k holds the byte received k+1 bytes ago.
    // Every accepted byte shifts the whole line, so the byte held in cell k is
    // compared against delimiter byte lm1-1-k, and the newest byte against
    // delimiter byte lm1. The match result ripples down the chain of cells.
    assign head_match = (s_data_byte == dmd_pkg::delim_byte(delim_reg, lm1));

    for (genvar k = 0; k < dmd_pkg::CELLS; k++) begin : g_cell
        assign cell_ctl[k].shift    = in_acc;
        assign cell_ctl[k].in_use   = (dmd_pkg::IDX_W'(k) < lm1);
        assign cell_ctl[k].expected = dmd_pkg::delim_byte(delim_reg,
                                          lm1 - dmd_pkg::IDX_W'(k) - dmd_pkg::IDX_W'(1));
        dmd_cell u_cell (
            .aclk      (aclk),
            .ctl       (cell_ctl[k]),
            .byte_in   ((k == 0) ? s_data_byte : cell_byte[(k == 0) ? 0 : k - 1]),
            .match_in  ((k == 0) ? head_match : cell_match[(k == 0) ? 0 : k - 1]),
            .byte_out  (cell_byte[k]),
            .match_out (cell_match[k])
        );
    end

    assign match = cell_match[dmd_pkg::CELLS - 1];

    // The byte that leaves a full window is the oldest of the candidate bytes.
    assign oldest_byte = (lm1 == '0) ? s_data_byte
                                     : cell_byte[lm1 - dmd_pkg::IDX_W'(1)];

    always_comb begin
        held_count_next = held_count_reg;
        msg_count_next  = msg_count_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        is_end_next     = is_end_reg;
        out_byte_next   = out_byte_reg;
        length_next     = length_reg;
        status_next     = status_reg;

        if (in_acc) begin
            if (!full) begin
                // Still filling the window: nothing leaves yet.
                held_count_next = held_eff + dmd_pkg::IDX_W'(1);
            end else if (match) begin
                // Delimiter found: report the message and restart the search.
                held_count_next = '0;
                msg_count_next  = '0;
                m_valid_next    = 1'b1;
                is_end_next     = 1'b1;
                out_byte_next   = '0;
                if (msg_count_reg == '0) begin
                    length_next = '0;
                    status_next = dmd_pkg::STATUS_EMPTY;
                end else if (msg_count_reg > max_ext) begin
                    length_next = max_ext + dmd_pkg::COUNT_W'(1);
                    status_next = dmd_pkg::STATUS_TOO_LONG;
                end else begin
                    length_next = msg_count_reg;
                    status_next = dmd_pkg::STATUS_ACCEPTED;
                end
            end else begin
                // No match with a full window: the oldest byte is message data.
                held_count_next = lm1;
                m_valid_next    = 1'b1;
                is_end_next     = 1'b0;
                out_byte_next   = oldest_byte;
                length_next     = '0;
                status_next     = dmd_pkg::STATUS_ACCEPTED;
                if (msg_count_reg <= max_ext) begin
                    msg_count_next = msg_count_reg + dmd_pkg::COUNT_W'(1);
                end
            end
        end

        // Rewriting the length discards whatever the window holds.
        if (cfg_acc && cfg_index == dmd_pkg::CFG_DELIM_LENGTH) begin
            held_count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg      <= dmd_pkg::DELIM_W'(10);
            len_reg        <= dmd_pkg::LEN_W'(1);
            max_reg        <= dmd_pkg::MAXSZ_W'(1024);
            held_count_reg <= '0;
            msg_count_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            held_count_reg <= held_count_next;
            msg_count_reg  <= msg_count_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_acc) begin
                case (cfg_index)
                    dmd_pkg::CFG_DELIM_BYTES:  delim_reg <= cfg_data;
                    dmd_pkg::CFG_DELIM_LENGTH: len_reg   <= cfg_data[dmd_pkg::LEN_W-1:0];
                    dmd_pkg::CFG_MAX_SIZE:     max_reg   <= cfg_data[dmd_pkg::MAXSZ_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Result payload needs no reset; it is qualified by m_valid.
    always_ff @(posedge aclk) begin
        is_end_reg   <= is_end_next;
        out_byte_reg <= out_byte_next;
        length_reg   <= length_next;
        status_reg   <= status_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_is_end         = is_end_reg;
    assign m_out_byte       = out_byte_reg;
    assign m_message_length = length_reg;
    assign m_status         = status_reg;

    // The window never holds more bytes than the delimiter length minus one.
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg <= lm1)
        else $error("held byte count exceeds delimiter length minus one");

    // A data transaction carries neither a length nor a status.
    a_data_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_end) |-> (m_message_length == '0 && m_status == 2'd0))
        else $error("data transaction with nonzero length or status");

    // An accepted message is never empty, and an empty one reports length zero.
    a_end_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_end) |->
        ((m_status == dmd_pkg::STATUS_EMPTY && m_message_length == '0) ||
         (m_status == dmd_pkg::STATUS_ACCEPTED && m_message_length != '0) ||
         (m_status == dmd_pkg::STATUS_TOO_LONG && m_message_length != '0)))
        else $error("end transaction length does not fit its status");

    // A matched delimiter restarts both the window and the message count.
    a_match_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && full && match) |=> (held_count_reg == '0 && msg_count_reg == '0))
        else $error("state not cleared after a delimiter match");

    // A byte taken into a full window always produces a result.
    a_full_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && full) |=> m_valid)
        else $error("full window produced no result");

endmodule

// ===== design/dmd_cell.sv =====
// One holding cell: stores a byte of the window and extends the match chain.
module dmd_cell (
    input  logic                        aclk,
    input  dmd_pkg::cell_ctl_t          ctl,
    input  logic [dmd_pkg::BYTE_W-1:0]  byte_in,
    input  logic                        match_in,
    output logic [dmd_pkg::BYTE_W-1:0]  byte_out,
    output logic                        match_out
);

    logic [dmd_pkg::BYTE_W-1:0] byte_reg;

    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            byte_reg <= byte_in;
        end
    end

    // A cell beyond the active delimiter length does not take part in the match.
    assign match_out = match_in & (~ctl.in_use | (byte_reg == ctl.expected));
    assign byte_out  = byte_reg;

endmodule
